// ===== rtl/cmau_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the checked memory atomic unit.
// No dependencies; used by cmau_front, cmau_back and the top level.
package cmau_pkg;

  localparam int REGION_WORDS = 1024;
  localparam int IDX_W        = (REGION_WORDS > 1) ? $clog2(REGION_WORDS) : 1;
  localparam int MEM_BYTES    = REGION_WORDS * 8;

  localparam int ACT_W  = 2;
  localparam int OFFS_W = 13;
  localparam int CNT_W  = 4;
  localparam int DATA_W = 64;
  localparam int SIZE_W = 14;
  localparam int RGT_W  = 3;
  localparam int STAT_W = 2;
  localparam int OPS_W  = 32;
  localparam int BYT_W  = 48;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CAS   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DENIED   = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd3;

  localparam logic REG_SIZE   = 1'b0;
  localparam logic REG_RIGHTS = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET   = 14'd8192;
  localparam logic [RGT_W-1:0]  RIGHTS_RESET = 3'd7;

  localparam logic [RGT_W-1:0] RGT_READ   = 3'b001;
  localparam logic [RGT_W-1:0] RGT_WRITE  = 3'b010;
  localparam logic [RGT_W-1:0] RGT_ATOMIC = 3'b100;

  localparam logic [CNT_W-1:0] FULL_WORD = 4'd8;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  len;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] cdata;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] rdata;
    logic [OPS_W-1:0]  rd_total;
    logic [OPS_W-1:0]  wr_total;
    logic [BYT_W-1:0]  byte_total;
  } res_t;

  function automatic logic [DATA_W-1:0] low_bytes_mask(input logic [CNT_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i*8 +: 8] = (CNT_W'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/cmau_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, access checks and a two-entry command queue.
// Depends on cmau_pkg.
module cmau_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [cmau_pkg::ACT_W-1:0]   in_action,
  input  logic [cmau_pkg::OFFS_W-1:0]  in_byte_offset,
  input  logic [cmau_pkg::CNT_W-1:0]   in_byte_count,
  input  logic [cmau_pkg::DATA_W-1:0]  in_write_data,
  input  logic [cmau_pkg::DATA_W-1:0]  in_compare_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [cmau_pkg::SIZE_W-1:0]  cfg_wdata,
  input  logic                         clearing,
  output logic                         cmd_valid,
  output cmau_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);

  logic [cmau_pkg::SIZE_W-1:0] size_r;
  logic [cmau_pkg::RGT_W-1:0]  rights_r;
  cmau_pkg::cmd_t              q_r [2];
  logic                        wp_r, rp_r;
  logic [1:0]                  cnt_r;

  logic                        push;
  logic [cmau_pkg::SIZE_W-1:0] lim;
  logic [cmau_pkg::CNT_W-1:0]  len;
  logic [cmau_pkg::SIZE_W:0]   end_byte;
  logic [cmau_pkg::RGT_W-1:0]  need;
  cmau_pkg::cmd_t              cls;

  always_comb begin
    lim = size_r;
    if (cmau_pkg::MEM_BYTES < (1 << cmau_pkg::SIZE_W) &&
        size_r > cmau_pkg::SIZE_W'(cmau_pkg::MEM_BYTES)) begin
      lim = cmau_pkg::SIZE_W'(cmau_pkg::MEM_BYTES);
    end
    len = (in_action == cmau_pkg::ACT_WRITE || in_action == cmau_pkg::ACT_READ) ?
          in_byte_count : cmau_pkg::FULL_WORD;
    end_byte = (cmau_pkg::SIZE_W+1)'(in_byte_offset) + (cmau_pkg::SIZE_W+1)'(len);
    case (in_action)
      cmau_pkg::ACT_WRITE: need = cmau_pkg::RGT_WRITE;
      cmau_pkg::ACT_READ:  need = cmau_pkg::RGT_READ;
      default:             need = cmau_pkg::RGT_ATOMIC;
    endcase
    cls.action = in_action;
    cls.idx    = cmau_pkg::IDX_W'(in_byte_offset[cmau_pkg::OFFS_W-1:3]);
    cls.len    = len;
    cls.wdata  = in_write_data;
    cls.cdata  = in_compare_data;
    if (in_byte_offset[2:0] != 3'd0) begin
      cls.status = cmau_pkg::ST_INVALID;
    end else if (len == '0 || len > cmau_pkg::FULL_WORD) begin
      cls.status = cmau_pkg::ST_INVALID;
    end else if (end_byte > (cmau_pkg::SIZE_W+1)'(lim)) begin
      cls.status = cmau_pkg::ST_INVALID;
    end else if ((rights_r & need) == '0) begin
      cls.status = cmau_pkg::ST_DENIED;
    end else begin
      cls.status = cmau_pkg::ST_OK;
    end
  end

  assign in_full   = (cnt_r == 2'd2) || clearing;
  assign push      = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= cmau_pkg::SIZE_RESET;
      rights_r <= cmau_pkg::RIGHTS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == cmau_pkg::REG_SIZE) begin
        size_r <= cfg_wdata;
      end else begin
        rights_r <= cfg_wdata[cmau_pkg::RGT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

  a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != 2'd0) else $error("command pop from empty queue");
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !cmd_pop |=> cnt_r == 2'd2) else $error("queue count lost");
  a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |=> $stable(cnt_r) || $past(cmd_pop)) else $error("push during clear");

endmodule

// ===== rtl/cmau_back.sv =====
`timescale 1ns / 1ps
// Back end: region memory with clearing pass, execution of accesses, counters
// and a two-entry result queue. Depends on cmau_pkg.
module cmau_back (
  input  logic           clk,
  input  logic           rst_n,
  output logic           clearing,
  input  logic           cmd_valid,
  input  cmau_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_empty,
  input  logic           res_pop,
  output cmau_pkg::res_t res
);

  localparam logic [1:0] BS_CLEAR = 2'd0;
  localparam logic [1:0] BS_IDLE  = 2'd1;
  localparam logic [1:0] BS_EXEC  = 2'd2;

  logic [cmau_pkg::DATA_W-1:0] mem [cmau_pkg::REGION_WORDS];
  logic [cmau_pkg::DATA_W-1:0] rd_r;

  logic [1:0]                  state_r, state_nxt;
  logic [cmau_pkg::IDX_W-1:0]  clr_r;
  cmau_pkg::cmd_t              cur_r;
  logic [cmau_pkg::OPS_W-1:0]  rcnt_r, rcnt_nxt, wcnt_r, wcnt_nxt;
  logic [cmau_pkg::BYT_W-1:0]  bcnt_r, bcnt_nxt;

  cmau_pkg::res_t              q_r [2];
  logic                        wp_r, rp_r;
  logic [1:0]                  qcnt_r;

  logic                        exec;
  logic                        mem_we;
  logic [cmau_pkg::IDX_W-1:0]  mem_addr;
  logic [cmau_pkg::DATA_W-1:0] mem_wdata, new_word, m;
  cmau_pkg::res_t              rsl;

  assign clearing  = (state_r == BS_CLEAR);
  assign cmd_pop   = (state_r == BS_IDLE) && cmd_valid && (qcnt_r != 2'd2);
  assign exec      = (state_r == BS_EXEC);
  assign res_empty = (qcnt_r == 2'd0);
  assign res       = q_r[rp_r];

  always_comb begin
    m        = cmau_pkg::low_bytes_mask(cur_r.len);
    new_word = rd_r;
    rcnt_nxt = rcnt_r;
    wcnt_nxt = wcnt_r;
    bcnt_nxt = bcnt_r;
    rsl.status = cur_r.status;
    rsl.rdata  = '0;
    mem_we     = 1'b0;
    if (cur_r.status == cmau_pkg::ST_OK) begin
      case (cur_r.action)
        cmau_pkg::ACT_WRITE: begin
          new_word = (rd_r & ~m) | (cur_r.wdata & m);
          mem_we   = 1'b1;
          wcnt_nxt = wcnt_r + 1'b1;
          bcnt_nxt = bcnt_r + cmau_pkg::BYT_W'(cur_r.len);
        end
        cmau_pkg::ACT_READ: begin
          rsl.rdata = rd_r & m;
          rcnt_nxt  = rcnt_r + 1'b1;
          bcnt_nxt  = bcnt_r + cmau_pkg::BYT_W'(cur_r.len);
        end
        cmau_pkg::ACT_ADD: begin
          new_word = rd_r + cur_r.wdata;
          mem_we   = 1'b1;
        end
        default: begin
          rsl.rdata = rd_r;
          if (rd_r == cur_r.cdata) begin
            new_word = cur_r.wdata;
            mem_we   = 1'b1;
          end else begin
            rsl.status = cmau_pkg::ST_MISMATCH;
          end
        end
      endcase
    end
    rsl.rd_total   = rcnt_nxt;
    rsl.wr_total   = wcnt_nxt;
    rsl.byte_total = bcnt_nxt;
    if (clearing) begin
      mem_addr  = clr_r;
      mem_wdata = '0;
    end else begin
      mem_addr  = cur_r.idx;
      mem_wdata = new_word;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_CLEAR: if (clr_r == cmau_pkg::IDX_W'(cmau_pkg::REGION_WORDS - 1)) state_nxt = BS_IDLE;
      BS_IDLE:  if (cmd_pop) state_nxt = BS_EXEC;
      BS_EXEC:  state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clearing || (exec && mem_we)) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_r <= mem[cmd.idx];
    if (cmd_pop) begin
      cur_r <= cmd;
    end
    if (exec) begin
      q_r[wp_r] <= rsl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_CLEAR;
      clr_r   <= '0;
      rcnt_r  <= '0;
      wcnt_r  <= '0;
      bcnt_r  <= '0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      qcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (exec) begin
        rcnt_r <= rcnt_nxt;
        wcnt_r <= wcnt_nxt;
        bcnt_r <= bcnt_nxt;
        wp_r   <= ~wp_r;
      end
      if (res_pop && !res_empty) rp_r <= ~rp_r;
      qcnt_r <= qcnt_r + 2'(exec) - 2'(res_pop && !res_empty);
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> qcnt_r != 2'd2) else $error("result queue overflow");
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> state_r == BS_IDLE) else $error("execute stage held");
  a_exec_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> $past(cmd_pop)) else $error("execute without command");
  a_clear_counters: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> rcnt_r == '0 && wcnt_r == '0 && bcnt_r == '0)
    else $error("counters moved during clear");

endmodule

// ===== rtl/checked_memory_atomic_unit.sv =====
`timescale 1ns / 1ps
// Checked memory atomic unit: 1024 x 64-bit region memory with write, read,
// atomic add and compare-and-swap. After reset the memory is swept to zero word
// by word, during which in_full stays high; configuration writes are taken
// throughout. Each access then passes the back end as a registered memory read
// followed by the modify and write-back on the memory write port, and no new
// command is taken until that write-back is done. A two-entry command queue
// and a two-entry result queue let the input and output sides stall apart.
// Depends on cmau_pkg, cmau_front and cmau_back.
module checked_memory_atomic_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [cmau_pkg::ACT_W-1:0]   in_action,
  input  logic [cmau_pkg::OFFS_W-1:0]  in_byte_offset,
  input  logic [cmau_pkg::CNT_W-1:0]   in_byte_count,
  input  logic [cmau_pkg::DATA_W-1:0]  in_write_data,
  input  logic [cmau_pkg::DATA_W-1:0]  in_compare_data,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [cmau_pkg::STAT_W-1:0]  out_status,
  output logic [cmau_pkg::DATA_W-1:0]  out_read_data,
  output logic [cmau_pkg::OPS_W-1:0]   out_read_total,
  output logic [cmau_pkg::OPS_W-1:0]   out_write_total,
  output logic [cmau_pkg::BYT_W-1:0]   out_bytes_total,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [cmau_pkg::SIZE_W-1:0]  cfg_wdata
);

  logic           clearing;
  logic           cmd_valid;
  logic           cmd_pop;
  cmau_pkg::cmd_t cmd;
  cmau_pkg::res_t res;

  cmau_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_byte_offset  (in_byte_offset),
    .in_byte_count   (in_byte_count),
    .in_write_data   (in_write_data),
    .in_compare_data (in_compare_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .clearing        (clearing),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  cmau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res       (res)
  );

  assign out_status      = res.status;
  assign out_read_data   = res.rdata;
  assign out_read_total  = res.rd_total;
  assign out_write_total = res.wr_total;
  assign out_bytes_total = res.byte_total;

endmodule

// ===== bench/tb_checked_memory_atomic_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for checked_memory_atomic_unit: queue-style in/out channels,
// a mirror of the region memory and counters predicts every result in order.
// Depends on cmau_pkg and the checked_memory_atomic_unit RTL.
module tb_checked_memory_atomic_unit;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 13;
  localparam int PHASE_ITEMS  = 115;
  localparam int SQUEEZE_ITEMS = 60;

  typedef enum {DRAIN_FULL, DRAIN_HALF, DRAIN_SLOW, DRAIN_PERIODIC} drain_mode_t;

  class region_mirror;
    logic [cmau_pkg::DATA_W-1:0] words [cmau_pkg::REGION_WORDS];
    logic [cmau_pkg::OPS_W-1:0]  reads;
    logic [cmau_pkg::OPS_W-1:0]  writes;
    logic [cmau_pkg::BYT_W-1:0]  bytes_moved;
    logic [cmau_pkg::SIZE_W-1:0] size_limit;
    logic [cmau_pkg::RGT_W-1:0]  rights;
    cmau_pkg::res_t              expected_q[$];
    int                          mismatches;

    function new();
      foreach (words[i]) words[i] = '0;
      reads       = '0;
      writes      = '0;
      bytes_moved = '0;
      size_limit  = cmau_pkg::SIZE_RESET;
      rights      = cmau_pkg::RIGHTS_RESET;
      mismatches  = 0;
    endfunction

    function void set_reg(logic idx, logic [cmau_pkg::SIZE_W-1:0] value);
      if (idx == cmau_pkg::REG_SIZE) size_limit = value;
      else rights = value[cmau_pkg::RGT_W-1:0];
    endfunction

    function int bound();
      return (int'(size_limit) < cmau_pkg::MEM_BYTES) ? int'(size_limit)
                                                     : cmau_pkg::MEM_BYTES;
    endfunction

    function logic [cmau_pkg::DATA_W-1:0] peek_word(int idx);
      return words[idx];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_access(logic [cmau_pkg::ACT_W-1:0] act,
                              logic [cmau_pkg::OFFS_W-1:0] off,
                              logic [cmau_pkg::CNT_W-1:0] cnt,
                              logic [cmau_pkg::DATA_W-1:0] wd,
                              logic [cmau_pkg::DATA_W-1:0] cd);
      int                          len;
      int                          idx;
      logic [cmau_pkg::RGT_W-1:0]  need;
      logic [cmau_pkg::DATA_W-1:0] m;
      cmau_pkg::res_t              e;
      len  = (act == cmau_pkg::ACT_WRITE || act == cmau_pkg::ACT_READ) ? int'(cnt) : 8;
      need = (act == cmau_pkg::ACT_WRITE) ? cmau_pkg::RGT_WRITE :
             (act == cmau_pkg::ACT_READ)  ? cmau_pkg::RGT_READ : cmau_pkg::RGT_ATOMIC;
      e.status = cmau_pkg::ST_OK;
      e.rdata  = '0;
      if (off[2:0] != 3'd0) e.status = cmau_pkg::ST_INVALID;
      else if (len == 0 || len > 8) e.status = cmau_pkg::ST_INVALID;
      else if (int'(off) + len > bound()) e.status = cmau_pkg::ST_INVALID;
      else if ((rights & need) == '0) e.status = cmau_pkg::ST_DENIED;
      if (e.status == cmau_pkg::ST_OK) begin
        idx = int'(off) >> 3;
        m = (len >= 8) ? {cmau_pkg::DATA_W{1'b1}} : ((64'd1 << (len * 8)) - 64'd1);
        case (act)
          cmau_pkg::ACT_WRITE: begin
            words[idx]  = (words[idx] & ~m) | (wd & m);
            writes      = writes + 1'b1;
            bytes_moved = bytes_moved + cmau_pkg::BYT_W'(len);
          end
          cmau_pkg::ACT_READ: begin
            e.rdata     = words[idx] & m;
            reads       = reads + 1'b1;
            bytes_moved = bytes_moved + cmau_pkg::BYT_W'(len);
          end
          cmau_pkg::ACT_ADD: words[idx] = words[idx] + wd;
          default: begin
            e.rdata = words[idx];
            if (words[idx] == cd) words[idx] = wd;
            else e.status = cmau_pkg::ST_MISMATCH;
          end
        endcase
      end
      e.rd_total   = reads;
      e.wr_total   = writes;
      e.byte_total = bytes_moved;
      expected_q.push_back(e);
    endfunction

    function void check_result(cmau_pkg::res_t got);
      cmau_pkg::res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no access pending: status %0d data %h",
                   $time, got.status, got.rdata);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.rdata !== want.rdata ||
          got.rd_total !== want.rd_total || got.wr_total !== want.wr_total ||
          got.byte_total !== want.byte_total) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp st %0d data %h rd %0d wr %0d bytes %0d",
                    " / got st %0d data %h rd %0d wr %0d bytes %0d"}, $time,
                   want.status, want.rdata, want.rd_total, want.wr_total, want.byte_total,
                   got.status, got.rdata, got.rd_total, got.wr_total, got.byte_total);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic [cmau_pkg::ACT_W-1:0]    in_action = cmau_pkg::ACT_WRITE;
  logic [cmau_pkg::OFFS_W-1:0]   in_byte_offset = '0;
  logic [cmau_pkg::CNT_W-1:0]    in_byte_count = '0;
  logic [cmau_pkg::DATA_W-1:0]   in_write_data = '0;
  logic [cmau_pkg::DATA_W-1:0]   in_compare_data = '0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic [cmau_pkg::STAT_W-1:0]   out_status;
  logic [cmau_pkg::DATA_W-1:0]   out_read_data;
  logic [cmau_pkg::OPS_W-1:0]    out_read_total;
  logic [cmau_pkg::OPS_W-1:0]    out_write_total;
  logic [cmau_pkg::BYT_W-1:0]    out_bytes_total;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = cmau_pkg::REG_SIZE;
  logic [cmau_pkg::SIZE_W-1:0]   cfg_wdata = '0;

  region_mirror mirror;
  int unsigned  cycle_count = 0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;
  int           mode_left = 0;
  drain_mode_t  drain_mode = DRAIN_FULL;

  checked_memory_atomic_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_action(in_action), .in_byte_offset(in_byte_offset),
    .in_byte_count(in_byte_count), .in_write_data(in_write_data),
    .in_compare_data(in_compare_data),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_status(out_status), .out_read_data(out_read_data),
    .out_read_total(out_read_total), .out_write_total(out_write_total),
    .out_bytes_total(out_bytes_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: own stall pattern plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 96);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      case (drain_mode)
        DRAIN_FULL: out_pop <= 1'b1;
        DRAIN_HALF: out_pop <= 1'($urandom_range(0, 1));
        DRAIN_SLOW: out_pop <= ($urandom_range(0, 3) == 0);
        default:    out_pop <= (mode_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      mirror.check_result('{status: out_status, rdata: out_read_data,
                            rd_total: out_read_total, wr_total: out_write_total,
                            byte_total: out_bytes_total});
  end

  task automatic drive_access(input logic [cmau_pkg::ACT_W-1:0] act,
                              input logic [cmau_pkg::OFFS_W-1:0] off,
                              input logic [cmau_pkg::CNT_W-1:0] cnt,
                              input logic [cmau_pkg::DATA_W-1:0] wd,
                              input logic [cmau_pkg::DATA_W-1:0] cd);
    @(negedge clk);
    in_push         <= 1'b1;
    in_action       <= act;
    in_byte_offset  <= off;
    in_byte_count   <= cnt;
    in_write_data   <= wd;
    in_compare_data <= cd;
    @(posedge clk);
    while (in_full) @(posedge clk);
    mirror.note_access(act, off, cnt, wd, cd);
  endtask

  task automatic pause_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    pause_input(1);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [cmau_pkg::SIZE_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    mirror.set_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed accesses on a few hot words so CAS and back-to-back updates of one word get exercised
  task automatic send_random_access();
    logic [cmau_pkg::ACT_W-1:0]  act;
    logic [cmau_pkg::OFFS_W-1:0] off;
    logic [cmau_pkg::CNT_W-1:0]  cnt;
    logic [cmau_pkg::DATA_W-1:0] wd;
    logic [cmau_pkg::DATA_W-1:0] cd;
    int                          lim_words;
    int                          idx;
    int                          pick;
    act = cmau_pkg::ACT_W'($urandom_range(0, 3));
    lim_words = mirror.bound() / 8;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      off = cmau_pkg::OFFS_W'($urandom_range(0, 8191));
    end else begin
      if (lim_words > 0 && pick < 90) begin
        case ($urandom_range(0, 3))
          0:       idx = $urandom_range(0, lim_words - 1);
          1:       idx = lim_words - 1;
          default: idx = $urandom_range(0, ((lim_words < 16) ? lim_words : 16) - 1);
        endcase
      end else begin
        idx = $urandom_range(0, cmau_pkg::REGION_WORDS - 1);
      end
      off = cmau_pkg::OFFS_W'(idx * 8);
    end
    if ((act == cmau_pkg::ACT_WRITE || act == cmau_pkg::ACT_READ) &&
        $urandom_range(0, 9) != 0)
      cnt = cmau_pkg::CNT_W'($urandom_range(1, 8));
    else
      cnt = cmau_pkg::CNT_W'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0:       wd = {cmau_pkg::DATA_W{1'b1}};
      1:       wd = cmau_pkg::DATA_W'($urandom_range(0, 3));
      default: wd = {$urandom, $urandom};
    endcase
    if (act == cmau_pkg::ACT_CAS && off[2:0] == 3'd0 && $urandom_range(0, 9) < 6)
      cd = mirror.peek_word(int'(off) >> 3);
    else
      cd = {$urandom, $urandom};
    drive_access(act, off, cnt, wd, cd);
  endtask

  initial begin
    logic [cmau_pkg::SIZE_W-1:0] size_val;
    int                          burst_left;
    mirror = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(cmau_pkg::REG_SIZE, cmau_pkg::SIZE_RESET);
    write_reg(cmau_pkg::REG_RIGHTS, cmau_pkg::RIGHTS_RESET);
    drive_access(cmau_pkg::ACT_READ,  13'd0,    4'd8,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_WRITE, 13'd0,    4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    drive_access(cmau_pkg::ACT_WRITE, 13'd8,    4'd1,  64'h0123_4567_89AB_CDEF, 64'h0);
    drive_access(cmau_pkg::ACT_WRITE, 13'd8184, 4'd8,  64'hDEAD_BEEF_0BAD_F00D, 64'h0);
    drive_access(cmau_pkg::ACT_READ,  13'd8184, 4'd2,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_READ,  13'd8191, 4'd8,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_WRITE, 13'd3,    4'd8,  64'h1, 64'h0);
    drive_access(cmau_pkg::ACT_ADD,   13'd5,    4'd8,  64'h1, 64'h0);
    drive_access(cmau_pkg::ACT_CAS,   13'd7,    4'd8,  64'h1, 64'h0);
    drive_access(cmau_pkg::ACT_READ,  13'd0,    4'd0,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_WRITE, 13'd0,    4'd15, 64'h5, 64'h0);
    drive_access(cmau_pkg::ACT_READ,  13'd0,    4'd9,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_ADD,   13'd0,    4'd0,  64'h1, 64'h0);
    drive_access(cmau_pkg::ACT_ADD,   13'd16,   4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    drive_access(cmau_pkg::ACT_CAS,   13'd16,   4'd0,  64'h123, 64'hFFFF_FFFF_FFFF_FFFF);
    drive_access(cmau_pkg::ACT_CAS,   13'd16,   4'd8,  64'h456, 64'h0);
    drive_access(cmau_pkg::ACT_READ,  13'd8,    4'd8,  64'h0, 64'h0);
    wait_idle();
    write_reg(cmau_pkg::REG_SIZE, 14'd16);
    drive_access(cmau_pkg::ACT_READ,  13'd8,    4'd8,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_READ,  13'd16,   4'd1,  64'h0, 64'h0);
    wait_idle();
    write_reg(cmau_pkg::REG_SIZE, 14'd0);
    drive_access(cmau_pkg::ACT_WRITE, 13'd0,    4'd1,  64'h7, 64'h0);
    wait_idle();
    write_reg(cmau_pkg::REG_SIZE, {cmau_pkg::SIZE_W{1'b1}});
    write_reg(cmau_pkg::REG_RIGHTS, 14'd0);
    drive_access(cmau_pkg::ACT_READ,  13'd8184, 4'd8,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_CAS,   13'd0,    4'd8,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_READ,  13'd8191, 4'd8,  64'h0, 64'h0);
    wait_idle();
    write_reg(cmau_pkg::REG_RIGHTS, {11'h7FF, cmau_pkg::RGT_READ});
    drive_access(cmau_pkg::ACT_READ,  13'd16,   4'd8,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_WRITE, 13'd16,   4'd8,  64'h9, 64'h0);
    wait_idle();
    write_reg(cmau_pkg::REG_RIGHTS, 14'(cmau_pkg::RGT_WRITE | cmau_pkg::RGT_ATOMIC));
    drive_access(cmau_pkg::ACT_READ,  13'd16,   4'd8,  64'h0, 64'h0);
    drive_access(cmau_pkg::ACT_ADD,   13'd16,   4'd8,  64'h2, 64'h0);

    // receiver holds off while the sender keeps pushing back to back
    wait_idle();
    write_reg(cmau_pkg::REG_SIZE, cmau_pkg::SIZE_RESET);
    write_reg(cmau_pkg::REG_RIGHTS, cmau_pkg::RIGHTS_RESET);
    hold_requests++;
    repeat (SQUEEZE_ITEMS) send_random_access();

    burst_left = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       size_val = '0;
        1:       size_val = {cmau_pkg::SIZE_W{1'b1}};
        2:       size_val = cmau_pkg::SIZE_W'($urandom_range(1, 80));
        3:       size_val = cmau_pkg::SIZE_W'($urandom);
        default: size_val = cmau_pkg::SIZE_RESET;
      endcase
      write_reg(cmau_pkg::REG_SIZE, size_val);
      if ($urandom_range(0, 1) == 0)
        write_reg(cmau_pkg::REG_RIGHTS,
                  {(cmau_pkg::SIZE_W - cmau_pkg::RGT_W)'($urandom_range(0, 2047)),
                   cmau_pkg::RIGHTS_RESET});
      else
        write_reg(cmau_pkg::REG_RIGHTS, cmau_pkg::SIZE_W'($urandom));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          pause_input($urandom_range(1, 8));
          burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        send_random_access();
        burst_left--;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
